// ----- sv/b64le_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64le_pkg
// Shared types and constants of the line-wrapped Base64 encoder.
// ----------------------------------------------------------------------------
package b64le_pkg;

    localparam int unsigned RecDepth = 8;
    localparam int unsigned IdxW = $clog2(RecDepth);
    localparam int unsigned CountW = $clog2(RecDepth + 1);

    localparam logic [7:0] LINE_LIMIT_RESET = 8'd76;
    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;
    localparam logic [7:0] CHAR_PAD = 8'd61;

    localparam logic REG_LINE_LIMIT = 1'b0;

    typedef logic [7:0] char_t;

    typedef enum logic [1:0] {
        PHASE_EMPTY,
        PHASE_ONE,
        PHASE_TWO
    } phase_t;

    // All characters that one input byte produces, in output order.
    typedef struct packed {
        char_t [RecDepth-1:0] chars;
        logic [CountW-1:0]    count;
        logic                 ends_msg;
    } rec_t;

    function automatic char_t b64_symbol(input logic [5:0] six);
        char_t ch;
        if (six < 6'd26)
        begin
            ch = 8'd65 + {2'b00, six};
        end
        else if (six < 6'd52)
        begin
            ch = 8'd71 + {2'b00, six};
        end
        else if (six < 6'd62)
        begin
            ch = {2'b00, six} - 8'd4;
        end
        else if (six == 6'd62)
        begin
            ch = 8'd43;
        end
        else
        begin
            ch = 8'd47;
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

// ----- sv/b64le_group.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64le_group
// Collects bytes into groups of three, tracks the line count and builds the
// full character record for each byte that produces output.
// ----------------------------------------------------------------------------
module b64le_group (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [7:0]       line_limit,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       data_byte,
    input  wire logic             last_byte,
    output logic                  rec_valid,
    output b64le_pkg::rec_t       rec,
    input  wire logic             rec_take
);

    b64le_pkg::phase_t phase_reg, phase_next;
    logic [15:0]       held_reg, held_next;
    logic [7:0]        line_count_reg, line_count_next;
    logic              rec_valid_reg, rec_valid_next;
    b64le_pkg::rec_t   rec_reg, rec_next;

    logic              accept;
    logic [7:0]        c1_two;
    logic [7:0]        c2_two;
    logic [7:0]        c1_one;
    logic [7:0]        thr;
    logic [8:0]        cnt;
    logic              brk;
    b64le_pkg::rec_t   build;

    assign in_ready = !rec_valid_reg || rec_take;
    assign accept = in_valid && in_ready;
    assign rec_valid = rec_valid_reg;
    assign rec = rec_reg;

    assign c1_two = held_reg[15:8];
    assign c2_two = held_reg[7:0];
    assign c1_one = held_reg[7:0];
    assign thr = (line_limit >= 8'd3) ? (line_limit - 8'd3) : 8'd0;
    assign cnt = {1'b0, line_count_reg} + 9'd4;
    assign brk = cnt >= {1'b0, thr};

    always_comb
    begin
        build = '0;
        build.ends_msg = last_byte;
        phase_next = phase_reg;
        held_next = held_reg;
        line_count_next = line_count_reg;
        case (phase_reg)
            b64le_pkg::PHASE_EMPTY:
            begin
                build.chars[0] = b64le_pkg::b64_symbol(data_byte[7:2]);
                build.chars[1] = b64le_pkg::b64_symbol({data_byte[1:0], 4'b0000});
                build.chars[2] = b64le_pkg::CHAR_PAD;
                build.chars[3] = b64le_pkg::CHAR_PAD;
                build.chars[4] = b64le_pkg::CHAR_CR;
                build.chars[5] = b64le_pkg::CHAR_LF;
                build.count = last_byte ? b64le_pkg::CountW'(6) : '0;
                held_next = {8'h00, data_byte};
                phase_next = b64le_pkg::PHASE_ONE;
            end
            b64le_pkg::PHASE_ONE:
            begin
                build.chars[0] = b64le_pkg::b64_symbol(c1_one[7:2]);
                build.chars[1] = b64le_pkg::b64_symbol({c1_one[1:0], data_byte[7:4]});
                build.chars[2] = b64le_pkg::b64_symbol({data_byte[3:0], 2'b00});
                build.chars[3] = b64le_pkg::CHAR_PAD;
                build.chars[4] = b64le_pkg::CHAR_CR;
                build.chars[5] = b64le_pkg::CHAR_LF;
                build.count = last_byte ? b64le_pkg::CountW'(6) : '0;
                held_next = {c1_one, data_byte};
                phase_next = b64le_pkg::PHASE_TWO;
            end
            default:
            begin
                build.chars[0] = b64le_pkg::b64_symbol(c1_two[7:2]);
                build.chars[1] = b64le_pkg::b64_symbol({c1_two[1:0], c2_two[7:4]});
                build.chars[2] = b64le_pkg::b64_symbol({c2_two[3:0], data_byte[7:6]});
                build.chars[3] = b64le_pkg::b64_symbol(data_byte[5:0]);
                build.chars[4] = b64le_pkg::CHAR_CR;
                build.chars[5] = b64le_pkg::CHAR_LF;
                build.chars[6] = b64le_pkg::CHAR_CR;
                build.chars[7] = b64le_pkg::CHAR_LF;
                build.count = b64le_pkg::CountW'(4) + (brk ? b64le_pkg::CountW'(2) : '0)
                    + (last_byte ? b64le_pkg::CountW'(2) : '0);
                held_next = 16'h0000;
                phase_next = b64le_pkg::PHASE_EMPTY;
                line_count_next = brk ? 8'd0 : cnt[7:0];
            end
        endcase
        if (last_byte)
        begin
            held_next = 16'h0000;
            phase_next = b64le_pkg::PHASE_EMPTY;
            line_count_next = 8'd0;
        end
        if (!accept)
        begin
            held_next = held_reg;
            phase_next = phase_reg;
            line_count_next = line_count_reg;
            rec_valid_next = rec_valid_reg && !rec_take;
            rec_next = rec_reg;
        end
        else
        begin
            rec_valid_next = build.count != '0;
            rec_next = build;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= b64le_pkg::PHASE_EMPTY;
            held_reg <= 16'h0000;
            line_count_reg <= 8'd0;
            rec_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            held_reg <= held_next;
            line_count_reg <= line_count_next;
            rec_valid_reg <= rec_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    a_rec_not_short: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid_reg |-> rec_reg.count >= b64le_pkg::CountW'(4))
        else $error("record holds fewer than four characters");

    a_msg_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_byte) |=> (phase_reg == b64le_pkg::PHASE_EMPTY
            && line_count_reg == 8'd0))
        else $error("message end did not clear the group state");

endmodule
`default_nettype wire

// ----- sv/b64le_serial.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64le_serial
// Holds one character record and sends its characters one per cycle, while the
// receiver is ready, through the output register.
// ----------------------------------------------------------------------------
module b64le_serial (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rec_valid,
    input  wire b64le_pkg::rec_t  rec,
    output logic                  rec_take,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [7:0]            out_char,
    output logic                  last_char
);

    b64le_pkg::rec_t              cur_reg, cur_next;
    logic [b64le_pkg::IdxW-1:0]   idx_reg, idx_next;
    logic                         busy_reg, busy_next;
    logic                         out_valid_reg, out_valid_next;
    logic [7:0]                   out_char_reg, out_char_next;
    logic                         last_char_reg, last_char_next;

    logic                         emit;
    logic                         last_idx;
    logic                         fin;

    assign last_idx = {1'b0, idx_reg} == (cur_reg.count - b64le_pkg::CountW'(1));
    assign emit = busy_reg && (!out_valid_reg || out_ready);
    assign fin = emit && last_idx;
    assign rec_take = rec_valid && (!busy_reg || fin);

    assign out_valid = out_valid_reg;
    assign out_char = out_char_reg;
    assign last_char = last_char_reg;

    always_comb
    begin
        cur_next = cur_reg;
        idx_next = idx_reg;
        busy_next = busy_reg;
        out_valid_next = out_valid_reg;
        out_char_next = out_char_reg;
        last_char_next = last_char_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_char_next = cur_reg.chars[idx_reg];
            last_char_next = cur_reg.ends_msg && last_idx;
            idx_next = idx_reg + 1'b1;
            if (last_idx)
            begin
                busy_next = 1'b0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (rec_take)
        begin
            cur_next = rec;
            idx_next = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            out_valid_reg <= out_valid_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_char_reg <= out_char_next;
        last_char_reg <= last_char_next;
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ({1'b0, idx_reg} < cur_reg.count))
        else $error("character index runs past the record");

    a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_char_reg) |-> out_char_reg == b64le_pkg::CHAR_LF)
        else $error("message closes on a character other than LF");

endmodule
`default_nettype wire

// ----- sv/base64_line_wrapped_encoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder
// Line-wrapped Base64 encoder with an APB register for the line limit.
//
// The input channel carries one message byte per transaction, with last_byte
// set on the final byte. The output channel carries one ASCII character per
// transaction: Base64 symbols, '=' padding, and CR LF line breaks. The closing
// LF of each message has last_char set.
// The first character of a byte's output passes through the record register,
// the serializer's current record and the output register. Characters leave
// at one per cycle while the receiver is ready, limited by the single output
// register. A group of three bytes yields four to eight characters and a one-
// or two-byte tail yields six. A byte is accepted while earlier characters are
// still being sent, as long as the one-record buffer between the two stages is
// free.
// When the receiver stalls, the output holds its character and the buffer
// fills; the input then waits. Reset clears the group state and line count,
// empties both stages and sets the line limit to 76.
// ----------------------------------------------------------------------------
module base64_line_wrapped_encoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       out_char,
    output logic             last_char
);

    logic [7:0]      line_limit_reg, line_limit_next;
    logic            cfg_write;
    logic            rec_valid;
    logic            rec_take;
    b64le_pkg::rec_t rec;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        line_limit_next = line_limit_reg;
        if (cfg_write && paddr[2] == b64le_pkg::REG_LINE_LIMIT)
        begin
            line_limit_next = pwdata[7:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == b64le_pkg::REG_LINE_LIMIT)
        begin
            prdata = {24'h000000, line_limit_reg};
        end
        else
        begin
            prdata = 32'h00000000;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_limit_reg <= b64le_pkg::LINE_LIMIT_RESET;
        end
        else
        begin
            line_limit_reg <= line_limit_next;
        end
    end

    b64le_group u_group (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_limit (line_limit_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .rec_valid  (rec_valid),
        .rec        (rec),
        .rec_take   (rec_take)
    );

    b64le_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec       (rec),
        .rec_take  (rec_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last_char (last_char)
    );

endmodule
`default_nettype wire

// ----- sim/tb_base64_line_wrapped_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_line_wrapped_encoder
// Self-checking testbench for the line-wrapped Base64 encoder.
//
// A short scripted sequence covers padding, line breaks, the double line break
// and register writes. Random messages follow under several line limits and
// handshake pressure patterns. A behavioral encoder, or a typed script row,
// predicts every character; a monitor checks each against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_base64_line_wrapped_encoder;

    localparam int unsigned CLK_HALF = 4;
    localparam int unsigned TIMEOUT_NS = 3_200_000;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam logic [2:0] LIMIT_ADDR = {b64le_pkg::REG_LINE_LIMIT, 2'b00};
    localparam logic [2:0] UNUSED_ADDR = 3'd4;
    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        b64le_pkg::char_t ch;
        logic             fin;
    } out_char_t;

    typedef enum logic {
        ROW_BYTE,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [2:0]  addr;
        logic [7:0]  value;
        logic        fin;
        logic        typed;
        logic [3:0]  n_typed;
        logic [63:0] typed_chars;
    } script_row_t;

    localparam int unsigned N_ROWS = 29;
    localparam script_row_t SCRIPT [N_ROWS] = '{
        '{ROW_BYTE,  LIMIT_ADDR, 8'h00, 1'b1, 1'b1, 4'd6,
          {"AA==", b64le_pkg::CHAR_CR, b64le_pkg::CHAR_LF, 16'h0000}},
        '{ROW_BYTE,  LIMIT_ADDR, 8'hFF, 1'b1, 1'b1, 4'd6,
          {"/w==", b64le_pkg::CHAR_CR, b64le_pkg::CHAR_LF, 16'h0000}},
        '{ROW_BYTE,  LIMIT_ADDR, 8'hFF, 1'b0, 1'b1, 4'd0, 64'h0},
        '{ROW_BYTE,  LIMIT_ADDR, 8'hFF, 1'b0, 1'b1, 4'd0, 64'h0},
        '{ROW_BYTE,  LIMIT_ADDR, 8'hFF, 1'b1, 1'b1, 4'd6,
          {"////", b64le_pkg::CHAR_CR, b64le_pkg::CHAR_LF, 16'h0000}},
        '{ROW_BYTE,  LIMIT_ADDR, 8'h00, 1'b0, 1'b1, 4'd0, 64'h0},
        '{ROW_BYTE,  LIMIT_ADDR, 8'h00, 1'b1, 1'b1, 4'd6,
          {"AAA=", b64le_pkg::CHAR_CR, b64le_pkg::CHAR_LF, 16'h0000}},
        '{ROW_BYTE,  LIMIT_ADDR, 8'hFF, 1'b0, 1'b1, 4'd0, 64'h0},
        '{ROW_BYTE,  LIMIT_ADDR, 8'hFF, 1'b1, 1'b1, 4'd6,
          {"//8=", b64le_pkg::CHAR_CR, b64le_pkg::CHAR_LF, 16'h0000}},
        '{ROW_BYTE,  LIMIT_ADDR, 8'h4D, 1'b0, 1'b0, 4'd0, 64'h0},
        '{ROW_BYTE,  LIMIT_ADDR, 8'h61, 1'b0, 1'b0, 4'd0, 64'h0},
        '{ROW_BYTE,  LIMIT_ADDR, 8'h6E, 1'b1, 1'b0, 4'd0, 64'h0},
        '{ROW_WRITE, LIMIT_ADDR, 8'd4,  1'b0, 1'b0, 4'd0, 64'h0},
        '{ROW_BYTE,  LIMIT_ADDR, 8'h00, 1'b0, 1'b1, 4'd0, 64'h0},
        '{ROW_BYTE,  LIMIT_ADDR, 8'h00, 1'b0, 1'b1, 4'd0, 64'h0},
        '{ROW_BYTE,  LIMIT_ADDR, 8'h00, 1'b1, 1'b1, 4'd8,
          {"AAAA", b64le_pkg::CHAR_CR, b64le_pkg::CHAR_LF,
           b64le_pkg::CHAR_CR, b64le_pkg::CHAR_LF}},
        '{ROW_BYTE,  LIMIT_ADDR, 8'h5A, 1'b0, 1'b0, 4'd0, 64'h0},
        '{ROW_BYTE,  LIMIT_ADDR, 8'hA5, 1'b0, 1'b0, 4'd0, 64'h0},
        '{ROW_BYTE,  LIMIT_ADDR, 8'h3C, 1'b0, 1'b0, 4'd0, 64'h0},
        '{ROW_BYTE,  LIMIT_ADDR, 8'hC3, 1'b1, 1'b0, 4'd0, 64'h0},
        '{ROW_WRITE, UNUSED_ADDR, 8'd9, 1'b0, 1'b0, 4'd0, 64'h0},
        '{ROW_BYTE,  LIMIT_ADDR, 8'hF0, 1'b0, 1'b0, 4'd0, 64'h0},
        '{ROW_BYTE,  LIMIT_ADDR, 8'h0F, 1'b0, 1'b0, 4'd0, 64'h0},
        '{ROW_BYTE,  LIMIT_ADDR, 8'h80, 1'b1, 1'b0, 4'd0, 64'h0},
        '{ROW_WRITE, LIMIT_ADDR, 8'd255, 1'b0, 1'b0, 4'd0, 64'h0},
        '{ROW_BYTE,  LIMIT_ADDR, 8'h01, 1'b0, 1'b0, 4'd0, 64'h0},
        '{ROW_BYTE,  LIMIT_ADDR, 8'hFE, 1'b1, 1'b0, 4'd0, 64'h0},
        '{ROW_WRITE, LIMIT_ADDR, 8'd76, 1'b0, 1'b0, 4'd0, 64'h0},
        '{ROW_BYTE,  LIMIT_ADDR, 8'h7E, 1'b1, 1'b0, 4'd0, 64'h0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_char;
    logic        last_char;

    // Behavioral encoder state.
    logic [7:0]        limit_reg = b64le_pkg::LINE_LIMIT_RESET;
    logic [15:0]       held_bytes = '0;
    b64le_pkg::phase_t group_phase = b64le_pkg::PHASE_EMPTY;
    logic [7:0]        line_count = '0;

    out_char_t   pending_chars[$];
    out_char_t   new_chars[$];
    int unsigned fail_count = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned hold_left = 0;

    base64_line_wrapped_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last_char (last_char)
    );

    initial
    begin
        forever
        begin
            #(CLK_HALF);
            clk = ~clk;
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

    function automatic void push_char(input b64le_pkg::char_t ch, input logic fin);
        new_chars.push_back('{ch: ch, fin: fin});
    endfunction

    function automatic void push_symbol(input logic [5:0] six);
        push_char(B64_ALPHABET[(63 - int'(six)) * 8 +: 8], 1'b0);
    endfunction

    function automatic void close_message();
        push_char(b64le_pkg::CHAR_CR, 1'b0);
        push_char(b64le_pkg::CHAR_LF, 1'b1);
        held_bytes = '0;
        group_phase = b64le_pkg::PHASE_EMPTY;
        line_count = '0;
    endfunction

    function automatic void encode_byte(input logic [7:0] b, input logic fin);
        logic [7:0] c1;
        logic [7:0] c2;
        logic [7:0] thr;
        logic [8:0] cnt;
        new_chars.delete();
        if (group_phase == b64le_pkg::PHASE_EMPTY)
        begin
            if (fin)
            begin
                push_symbol(b[7:2]);
                push_symbol({b[1:0], 4'd0});
                push_char(b64le_pkg::CHAR_PAD, 1'b0);
                push_char(b64le_pkg::CHAR_PAD, 1'b0);
                close_message();
            end
            else
            begin
                held_bytes = {8'd0, b};
                group_phase = b64le_pkg::PHASE_ONE;
            end
        end
        else if (group_phase == b64le_pkg::PHASE_ONE)
        begin
            c1 = held_bytes[7:0];
            if (fin)
            begin
                push_symbol(c1[7:2]);
                push_symbol({c1[1:0], b[7:4]});
                push_symbol({b[3:0], 2'd0});
                push_char(b64le_pkg::CHAR_PAD, 1'b0);
                close_message();
            end
            else
            begin
                held_bytes = {c1, b};
                group_phase = b64le_pkg::PHASE_TWO;
            end
        end
        else
        begin
            c1 = held_bytes[15:8];
            c2 = held_bytes[7:0];
            thr = (limit_reg >= 8'd3) ? limit_reg - 8'd3 : 8'd0;
            push_symbol(c1[7:2]);
            push_symbol({c1[1:0], c2[7:4]});
            push_symbol({c2[3:0], b[7:6]});
            push_symbol(b[5:0]);
            cnt = {1'b0, line_count} + 9'd4;
            if (cnt >= {1'b0, thr})
            begin
                push_char(b64le_pkg::CHAR_CR, 1'b0);
                push_char(b64le_pkg::CHAR_LF, 1'b0);
                cnt = '0;
            end
            line_count = cnt[7:0];
            held_bytes = '0;
            group_phase = b64le_pkg::PHASE_EMPTY;
            if (fin)
            begin
                close_message();
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                             input logic [3:0] n_typed, input logic [63:0] typed_chars);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct)
            begin
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        encode_byte(b, fin);
        if (typed)
        begin
            for (int k = 0; k < int'(n_typed); k++)
            begin
                pending_chars.push_back('{ch: typed_chars[63 - 8 * k -: 8],
                                          fin: fin && (k == int'(n_typed) - 1)});
            end
        end
        else
        begin
            foreach (new_chars[k])
            begin
                pending_chars.push_back(new_chars[k]);
            end
        end
    endtask

    task automatic finish_traffic();
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == LIMIT_ADDR)
        begin
            limit_reg = value;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        // Read the limit back; a write elsewhere must leave it untouched.
        psel <= 1'b1;
        pwrite <= 1'b0;
        paddr <= LIMIT_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {24'd0, limit_reg})
        begin
            $display("%0t: line_limit read expected %h, got %h", $time,
                     {24'd0, limit_reg}, prdata);
            fail_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        int unsigned sel;
        sel = $urandom_range(15);
        if (sel == 0)
        begin
            return 8'h00;
        end
        else if (sel == 1)
        begin
            return 8'hFF;
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic run_phase(input logic [7:0] limit, input int unsigned tx_pct,
                             input int unsigned rx_pct, input int unsigned hold,
                             input int unsigned target);
        int unsigned sent;
        int unsigned msg_len;
        sent = 0;
        write_reg(LIMIT_ADDR, limit);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        hold_left = hold;
        while (sent < target)
        begin
            msg_len = ($urandom_range(7) == 0) ? $urandom_range(70, 40)
                                               : $urandom_range(12, 1);
            for (int i = 0; i < int'(msg_len); i++)
            begin
                send_byte(pick_byte(), i == int'(msg_len) - 1, 1'b0, 4'd0, 64'h0);
            end
            sent += msg_len;
        end
        finish_traffic();
    endtask

    // The receiver counts down a long hold-off before it resumes random stalls.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : char_monitor
        out_char_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected character, expected none, got %h last %b",
                         $time, out_char, last_char);
                fail_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (out_char !== want.ch)
                begin
                    $display("%0t: out_char expected %h, got %h", $time, want.ch, out_char);
                    fail_count++;
                end
                if (last_char !== want.fin)
                begin
                    $display("%0t: last_char expected %b, got %b", $time, want.fin,
                             last_char);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int r = 0; r < int'(N_ROWS); r++)
        begin
            if (SCRIPT[r].kind == ROW_WRITE)
            begin
                finish_traffic();
                write_reg(SCRIPT[r].addr, SCRIPT[r].value);
            end
            else
            begin
                send_byte(SCRIPT[r].value, SCRIPT[r].fin, SCRIPT[r].typed,
                          SCRIPT[r].n_typed, SCRIPT[r].typed_chars);
            end
        end
        finish_traffic();
        run_phase(8'd76, 0, 0, 0, 30);
        run_phase(8'd4, 71, 0, 0, 25);
        run_phase(8'd255, 0, 71, 0, 25);
        run_phase(8'($urandom_range(254, 5)), 22, 22, 0, 30);
        run_phase(8'd7, 0, 0, 300, 35);
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
